### sv/rns_pkg.sv
// shared types and constants for the radius neighbor search core
package rns_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int PT_CW      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W - 1;
    localparam int DIST_W     = 34;
    localparam int CNT_W      = 7;
    localparam int MASK_W     = 64;
    localparam int IDX_W      = 6;

    localparam logic        REQ_WRITE = 1'b0;
    localparam logic        REQ_QUERY = 1'b1;

    localparam logic        CFG_ATOM_COUNT     = 1'b0;
    localparam logic        CFG_RADIUS_SQUARED = 1'b1;

    localparam logic [CNT_W-1:0]  ATOM_COUNT_RST = 7'd0;
    localparam logic [DIST_W-1:0] RADIUS_SQ_RST  = 34'd65536;

    typedef struct packed {
        logic                      req_type;
        logic [IDX_W-1:0]          point_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
    } rns_in_t;

    typedef struct packed {
        logic [MASK_W-1:0] neighbor_mask;
        logic [CNT_W-1:0]  neighbor_count;
    } rns_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic vld;
        logic en;
    } pipe_ctl_t;

    typedef struct packed {
        logic vld;
        logic hit;
    } hit_t;

endpackage

### sv/rns_cell.sv
// one cell of the neighbor mask chain, passes its bit to the lower neighbor
module rns_cell (
    input  logic clk,
    input  logic shift,
    input  logic din,
    output logic dout
);

    logic bit_reg;
    logic bit_next;

    always_comb
    begin
        bit_next = shift ? din : bit_reg;
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    assign dout = bit_reg;

endmodule

### sv/rns_dist.sv
// pipelined squared distance and radius compare unit
module rns_dist (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rns_pkg::pipe_ctl_t                ctl,
    input  rns_pkg::point_t                   q_pt,
    input  rns_pkg::point_t                   p_pt,
    input  logic [rns_pkg::DIST_W-1:0]        radius_sq,
    output rns_pkg::hit_t                     result
);
    import rns_pkg::*;

    pipe_ctl_t                s1_ctl_reg;
    pipe_ctl_t                s2_ctl_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic [SQ_W-1:0]          sx_reg;
    logic [SQ_W-1:0]          sy_reg;
    hit_t                     hit_reg;

    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic signed [2*DIFF_W-1:0] px_full;
    logic signed [2*DIFF_W-1:0] py_full;
    logic [DIST_W-1:0]        d2;
    hit_t                     hit_next;

    always_comb
    begin
        dx_next  = DIFF_W'(q_pt.x) - DIFF_W'(p_pt.x);
        dy_next  = DIFF_W'(q_pt.y) - DIFF_W'(p_pt.y);
        px_full  = dx_reg * dx_reg;
        py_full  = dy_reg * dy_reg;
        d2       = DIST_W'(sx_reg) + DIST_W'(sy_reg);
        hit_next.vld = s2_ctl_reg.vld;
        hit_next.hit = s2_ctl_reg.en && (d2 < radius_sq);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            hit_reg    <= '0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            s2_ctl_reg <= s1_ctl_reg;
            hit_reg    <= hit_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        sx_reg <= px_full[SQ_W-1:0];
        sy_reg <= py_full[SQ_W-1:0];
    end

    assign result = hit_reg;

    a_hit_needs_en: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg.hit |-> $past(s1_ctl_reg.en, 2) || $past(s2_ctl_reg.en))
        else $error("hit flagged for a disabled slot");

    a_vld_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_ctl_reg.vld |=> ##1 hit_reg.vld)
        else $error("pipeline dropped a valid slot");

    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_ctl_reg.vld && radius_sq == '0) |=> !hit_reg.hit)
        else $error("hit with zero radius");

endmodule

### sv/radius_neighbor_search_core.sv
// top level of the radius neighbor search core
//
// in_item channel (in_valid / in_stall): a write item stores one point
// position at point_index and gives no result. A query
// item sweeps every stored entry through a row of mask cells and gives one
// out_item with the neighbor mask and its popcount.
// A query does one read of the queried point, then one point memory read per
// cycle over all entries, then the distance pipeline. The point memory has a
// single read port, shared by the queried point read and the sweep.
// in_stall is high while a query is in flight; a new item is taken as soon
// as the previous result sits in the output register.
// out_item is held in an output register; while out_stall is high it holds
// and a finished query waits in its done state until the register is free.
// cfg channel (cfg_valid / cfg_ready): index 0 is atom_count, index 1 is
// radius_squared; cfg_ready is always high, write only while idle.
// Reset (rst_n, async low) returns to idle, clears the output valid and
// restores atom_count 0 and radius_squared 1.0. Point entries are undefined
// until written.
module radius_neighbor_search_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rns_pkg::rns_in_t              in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rns_pkg::rns_out_t             out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [rns_pkg::DIST_W-1:0]    cfg_data
);
    import rns_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QREAD = 3'd1;
    localparam logic [2:0] ST_QLOAD = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [CNT_W-1:0] MAX_PT7  = CNT_W'(MAX_POINTS);
    localparam logic [PT_CW-1:0] MAX_PTC  = PT_CW'(MAX_POINTS);
    localparam logic [PT_CW-1:0] LAST_PTC = PT_CW'(MAX_POINTS - 1);

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [CNT_W-1:0]    atom_count_reg;
    logic [DIST_W-1:0]   radius_sq_reg;
    logic [PT_AW-1:0]    q_idx_reg;
    logic                zero_reg;
    point_t              q_reg;
    logic [PT_CW-1:0]    limit_reg;
    logic [PT_CW-1:0]    issue_cnt_reg;
    logic [PT_CW-1:0]    done_cnt_reg;
    logic [CNT_W-1:0]    count_reg;
    pipe_ctl_t           p1_ctl_reg;
    point_t              rd_data_reg;
    logic                out_valid_reg;
    rns_out_t            out_item_reg;

    point_t              mem [MAX_POINTS];

    logic                in_accept;
    logic                idx_ok;
    logic                mem_we;
    logic [PT_AW-1:0]    rd_addr;
    logic                issuing;
    pipe_ctl_t           issue_ctl;
    hit_t                hit;
    logic                out_free;
    logic                out_load;
    logic [PT_CW-1:0]    limit_next;
    logic [MAX_POINTS-1:0] cell_bits;
    point_t              wr_pt;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        idx_ok     = ({1'b0, in_item.point_index} < MAX_PT7);
        mem_we     = in_accept && (in_item.req_type == REQ_WRITE) && idx_ok;
        wr_pt.x    = in_item.pos_x;
        wr_pt.y    = in_item.pos_y;
        issuing    = (state_reg == ST_SWEEP) && (issue_cnt_reg < MAX_PTC);
        issue_ctl.vld = issuing;
        issue_ctl.en  = issuing && (issue_cnt_reg < limit_reg);
        rd_addr    = (state_reg == ST_QREAD) ? q_idx_reg : issue_cnt_reg[PT_AW-1:0];
        out_free   = !out_valid_reg || !out_stall;
        out_load   = (state_reg == ST_DONE) && out_free;
        limit_next = (atom_count_reg > MAX_PT7) ? MAX_PTC : atom_count_reg[PT_CW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && in_item.req_type == REQ_QUERY)
                begin
                    state_next = idx_ok ? ST_QREAD : ST_DONE;
                end
            end
            ST_QREAD:
            begin
                state_next = ST_QLOAD;
            end
            ST_QLOAD:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (hit.vld && done_cnt_reg == LAST_PTC)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // point memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[in_item.point_index[PT_AW-1:0]] <= wr_pt;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            atom_count_reg <= ATOM_COUNT_RST;
            radius_sq_reg  <= RADIUS_SQ_RST;
            issue_cnt_reg  <= '0;
            done_cnt_reg   <= '0;
            p1_ctl_reg     <= '0;
            out_valid_reg  <= 1'b0;
            zero_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            p1_ctl_reg <= issue_ctl;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ATOM_COUNT:     atom_count_reg <= cfg_data[CNT_W-1:0];
                    CFG_RADIUS_SQUARED: radius_sq_reg  <= cfg_data;
                    default:            radius_sq_reg  <= radius_sq_reg;
                endcase
            end
            if (in_accept)
            begin
                zero_reg <= !idx_ok;
            end
            if (state_reg == ST_QLOAD)
            begin
                issue_cnt_reg <= '0;
                done_cnt_reg  <= '0;
            end
            else
            begin
                if (issuing)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (hit.vld)
                begin
                    done_cnt_reg <= done_cnt_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            q_idx_reg <= in_item.point_index[PT_AW-1:0];
        end
        if (state_reg == ST_QLOAD)
        begin
            q_reg     <= rd_data_reg;
            limit_reg <= limit_next;
            count_reg <= '0;
        end
        else if (hit.vld && hit.hit)
        begin
            count_reg <= count_reg + 1'b1;
        end
        if (out_load)
        begin
            out_item_reg.neighbor_mask  <= zero_reg ? '0 : MASK_W'(cell_bits);
            out_item_reg.neighbor_count <= zero_reg ? '0 : count_reg;
        end
    end

    rns_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (p1_ctl_reg),
        .q_pt      (q_reg),
        .p_pt      (rd_data_reg),
        .radius_sq (radius_sq_reg),
        .result    (hit)
    );

    // mask chain, new bits enter at the top cell
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        logic cell_in;
        if (i == MAX_POINTS - 1)
        begin : g_top
            assign cell_in = hit.hit;
        end
        else
        begin : g_mid
            assign cell_in = cell_bits[i+1];
        end
        rns_cell u_cell (
            .clk   (clk),
            .shift (hit.vld),
            .din   (cell_in),
            .dout  (cell_bits[i])
        );
    end

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_item.req_type == REQ_QUERY) |=>
            (state_reg == ST_QREAD || state_reg == ST_DONE))
        else $error("query did not start");

    a_hit_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        hit.vld |-> state_reg == ST_SWEEP)
        else $error("distance result outside sweep");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result not presented");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.neighbor_count <= MAX_PT7)
        else $error("neighbor count out of range");

endmodule

### sim/radius_neighbor_search_core_test.sv
// self-checking testbench for the radius neighbor search core
`timescale 1ns / 1ps

module radius_neighbor_search_core_test;
    import rns_pkg::*;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_QUERY,
        ROW_CFG_ATOMS,
        ROW_CFG_RADIUS
    } row_kind_e;

    typedef struct {
        row_kind_e         kind;
        logic [IDX_W-1:0]  idx;
        logic [15:0]       x;
        logic [15:0]       y;
        logic [DIST_W-1:0] cfg_val;
        bit                typed;
        rns_out_t          want;
    } stim_row_t;

    localparam int DRAIN_CYCLES = MAX_POINTS + 16;
    localparam int NUM_PHASES   = 6;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    rns_in_t           in_item;
    logic              out_valid;
    logic              out_stall = 1'b0;
    rns_out_t          out_item;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [DIST_W-1:0] cfg_data;

    point_t            point_table [MAX_POINTS];
    logic [CNT_W-1:0]  atoms_cfg;
    logic [DIST_W-1:0] radius_cfg;
    rns_out_t          pending_masks [$];
    stim_row_t         dir_rows [$];

    int src_pct;
    int snk_pct;
    int errors;
    int n_checked;
    int n_writes;
    int n_queries;

    radius_neighbor_search_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < snk_pct);
    end

    function automatic rns_out_t neighbors_of(logic [IDX_W-1:0] idx);
        rns_out_t           r;
        point_t             q;
        point_t             p;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [DIST_W-1:0]  d2;
        int                 lim;
        r   = '0;
        q   = point_table[idx];
        lim = (atoms_cfg > MAX_POINTS) ? MAX_POINTS : int'(atoms_cfg);
        for (int j = 0; j < lim; j++)
        begin
            p  = point_table[j];
            dx = q.x - p.x;
            dy = q.y - p.y;
            d2 = dx * dx + dy * dy;
            if (d2 < radius_cfg)
            begin
                r.neighbor_mask[j] = 1'b1;
                r.neighbor_count   = r.neighbor_count + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] rand_coord();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 1023)) - 16'd512;
    endfunction

    function automatic void add_row(row_kind_e kind, logic [IDX_W-1:0] idx,
                                    logic [15:0] x, logic [15:0] y,
                                    logic [DIST_W-1:0] cfg_val, bit typed,
                                    logic [MASK_W-1:0] mask, logic [CNT_W-1:0] cnt);
        stim_row_t r;
        r.kind                = kind;
        r.idx                 = idx;
        r.x                   = x;
        r.y                   = y;
        r.cfg_val             = cfg_val;
        r.typed               = typed;
        r.want.neighbor_mask  = mask;
        r.want.neighbor_count = cnt;
        dir_rows = {dir_rows, r};
    endfunction

    task automatic send_item(rns_in_t it, bit typed, rns_out_t want);
        rns_out_t exp_item;
        while ($urandom_range(0, 99) < src_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        if (it.req_type == REQ_WRITE)
        begin
            point_table[it.point_index] = '{x: it.pos_x, y: it.pos_y};
            n_writes++;
        end
        else
        begin
            exp_item      = typed ? want : neighbors_of(it.point_index);
            pending_masks = {pending_masks, exp_item};
            n_queries++;
        end
    endtask

    task automatic drain(int extra);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_masks.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [DIST_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ATOM_COUNT)
            atoms_cfg = val[CNT_W-1:0];
        else
            radius_cfg = val;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_masks.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result mask %h count %0d",
                             out_item.neighbor_mask, out_item.neighbor_count);
                errors++;
            end
            else
            begin
                if (out_item.neighbor_mask !== pending_masks[0].neighbor_mask ||
                    out_item.neighbor_count !== pending_masks[0].neighbor_count)
                begin
                    if (errors < 10)
                        $display("mismatch: mask exp %h got %h, count exp %0d got %0d",
                                 pending_masks[0].neighbor_mask, out_item.neighbor_mask,
                                 pending_masks[0].neighbor_count, out_item.neighbor_count);
                    errors++;
                end
                void'(pending_masks.pop_front());
                n_checked++;
            end
        end
    end

    initial
    begin
        #4800000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        static int                ph_atoms  [NUM_PHASES] = '{64, 127, 17, 1, 0, 64};
        static logic [DIST_W-1:0] ph_radius [NUM_PHASES] = '{34'd65536, 34'd262144,
                                                             34'd16384, 34'h3FFFFFFFF,
                                                             34'd65536, 34'd0};
        static int                ph_src    [NUM_PHASES] = '{0, 47, 0, 23, 0, 23};
        static int                ph_snk    [NUM_PHASES] = '{0, 0, 47, 23, 0, 23};
        static int                ph_items  [NUM_PHASES] = '{60, 120, 120, 80, 40, 120};
        rns_in_t           it;
        rns_out_t          none;

        none       = '0;
        src_pct    = 0;
        snk_pct    = 0;
        errors     = 0;
        n_checked  = 0;
        n_writes   = 0;
        n_queries  = 0;
        atoms_cfg  = ATOM_COUNT_RST;
        radius_cfg = RADIUS_SQ_RST;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_ATOM_COUNT;
        cfg_data   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset the count is zero, so the mask is empty
        add_row(ROW_WRITE, 0, 16'h0000, 16'h0000, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0, 16'hFFFF, 16'h8000, 0, 1, 64'h0, 7'd0);
        add_row(ROW_WRITE, 1, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0);
        add_row(ROW_WRITE, 2, 16'h8000, 16'h8000, 0, 0, 0, 0);
        add_row(ROW_WRITE, 3, 16'h0100, 16'h0000, 0, 0, 0, 0);
        add_row(ROW_WRITE, 4, 16'h0000, 16'h00FF, 0, 0, 0, 0);
        add_row(ROW_CFG_ATOMS, 0, 0, 0, 34'd5, 0, 0, 0);
        // distance exactly 1.0 to point 3 must not count
        add_row(ROW_QUERY, 0, 16'h0000, 16'h0000, 0, 0, 0, 0);
        add_row(ROW_QUERY, 3, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0);
        add_row(ROW_QUERY, 4, 16'h8000, 16'h0000, 0, 0, 0, 0);
        add_row(ROW_CFG_RADIUS, 0, 0, 0, 34'd0, 0, 0, 0);
        add_row(ROW_QUERY, 0, 16'h0000, 16'h0000, 0, 1, 64'h0, 7'd0);
        add_row(ROW_QUERY, 1, 16'h0000, 16'h0000, 0, 1, 64'h0, 7'd0);
        // widest radius covers even opposite corners
        add_row(ROW_CFG_RADIUS, 0, 0, 0, 34'h3FFFFFFFF, 0, 0, 0);
        add_row(ROW_QUERY, 1, 16'h0000, 16'h0000, 0, 1, 64'h1F, 7'd5);
        add_row(ROW_QUERY, 2, 16'h0000, 16'h0000, 0, 1, 64'h1F, 7'd5);
        // queried index above the count
        add_row(ROW_CFG_ATOMS, 0, 0, 0, 34'd2, 0, 0, 0);
        add_row(ROW_QUERY, 4, 16'h5555, 16'hAAAA, 0, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_CFG_ATOMS:
                begin
                    drain(DRAIN_CYCLES);
                    write_reg(CFG_ATOM_COUNT, dir_rows[i].cfg_val);
                end
                ROW_CFG_RADIUS:
                begin
                    drain(DRAIN_CYCLES);
                    write_reg(CFG_RADIUS_SQUARED, dir_rows[i].cfg_val);
                end
                default:
                begin
                    it.req_type    = (dir_rows[i].kind == ROW_WRITE) ? REQ_WRITE : REQ_QUERY;
                    it.point_index = dir_rows[i].idx;
                    it.pos_x       = dir_rows[i].x;
                    it.pos_y       = dir_rows[i].y;
                    send_item(it, dir_rows[i].typed, dir_rows[i].want);
                end
            endcase
        end

        ph_radius[5] = DIST_W'($urandom_range(0, 1 << 19));
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain(DRAIN_CYCLES);
            write_reg(CFG_ATOM_COUNT, DIST_W'(ph_atoms[p]));
            write_reg(CFG_RADIUS_SQUARED, ph_radius[p]);
            src_pct = ph_src[p];
            snk_pct = ph_snk[p];
            // fill every entry before random queries can touch it
            if (p == 0)
            begin
                for (int k = 0; k < MAX_POINTS; k++)
                begin
                    it.req_type    = REQ_WRITE;
                    it.point_index = IDX_W'(k);
                    it.pos_x       = rand_coord();
                    it.pos_y       = rand_coord();
                    send_item(it, 0, none);
                end
            end
            for (int k = 0; k < ph_items[p]; k++)
            begin
                if (p == 1 && k == 60)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_masks.size() != 0);
                end
                it.req_type    = ($urandom_range(0, 3) != 0) ? REQ_QUERY : REQ_WRITE;
                it.point_index = IDX_W'($urandom_range(0, MAX_POINTS - 1));
                it.pos_x       = rand_coord();
                it.pos_y       = rand_coord();
                send_item(it, 0, none);
            end
        end

        drain(DRAIN_CYCLES);
        $display("covered %0d point writes and %0d queries over %0d register settings",
                 n_writes, n_queries, NUM_PHASES + 5);
        $display("%0d results compared, %0d mismatches", n_checked, errors);
        if (errors == 0 && pending_masks.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
